// ===== hw/rtl/aom_pkg.sv =====
// aom_pkg: shared types, widths and constants of the autoranging ohmmeter
// used by autorange_ohmmeter and its port checker; no dependencies
`default_nettype none

package aom_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int THRESH_W      = 15;
    localparam int GAIN_W        = 16;
    localparam int RANGE_W       = 2;
    localparam int OHMS_W        = 32;
    localparam int SERIES_W      = 20;   // up to 1M ohm
    localparam int DIFF_W        = 15;   // 32768 - sample for sample in 1..32767
    localparam int PROD_W        = 51;   // diff * gain * series
    localparam int MUL_A_W       = DIFF_W + GAIN_W;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int DEF_GAIN_FRAC_BITS = 14;

    // config register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN0  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN1  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN2  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN3  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LOW    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_HIGH   = 3'd5;

    localparam logic [GAIN_W-1:0]   GAIN0_RST = 16'd16155;
    localparam logic [GAIN_W-1:0]   GAIN1_RST = 16'd15974;
    localparam logic [GAIN_W-1:0]   GAIN2_RST = 16'd16384;
    localparam logic [GAIN_W-1:0]   GAIN3_RST = 16'd10945;
    localparam logic [THRESH_W-1:0] LOW_RST   = 15'd8000;
    localparam logic [THRESH_W-1:0] HIGH_RST  = 15'd24000;

    localparam logic [RANGE_W-1:0] RANGE_MIN = 2'd0;
    localparam logic [RANGE_W-1:0] RANGE_MAX = 2'd3;

    // output stream layout: range, resistance_ohms, overflow from bit 0 up
    localparam int M_TDATA_W = 40;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MUL1 = 7'b0000010,
        ST_MUL2 = 7'b0000100,
        ST_SUM  = 7'b0001000,
        ST_CHK  = 7'b0010000,
        ST_DIV  = 7'b0100000,
        ST_FIN  = 7'b1000000
    } seq_state_t;

    function automatic logic [SERIES_W-1:0] series_ohms(input logic [RANGE_W-1:0] rg);
        logic [SERIES_W-1:0] r;
        case (rg)
            2'd0:    r = 20'd1000;
            2'd1:    r = 20'd10000;
            2'd2:    r = 20'd100000;
            2'd3:    r = 20'd1000000;
            default: r = 20'd1000;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/autorange_ohmmeter.sv =====
// autorange_ohmmeter: range selection and resistance computation for a
// voltage-divider ohmmeter; depends on aom_pkg
`default_nettype none

// Usage
//   s_ channel: one beat per settled ADC sample, s_tdata[15:0] signed counts
//   (1/16 mV). m_ channel: one beat per sample. m_tuser is done_res: high
//   when the range was accepted and the resistance is valid; low when the
//   range moved, then m_tdata carries the new range and zero otherwise.
//   cfg_ channel: register writes (gains 0..3, low and high thresholds),
//   always ready, other indexes ignored; the user must issue them only
//   while the block is idle, which the block itself never checks.
// Sequence
//   a range change or a nonpositive sample skips the datapath; one whose
//   reading does not fit in 32 bits stops after the compare; the rest take
//   two passes through the shared 31x20 multiplier, one rounding add, one
//   overflow compare, then the one-bit-per-cycle restoring divider. one
//   sample is in flight at a time; s_tready is low while it is worked on.
// Stalls and reset
//   a result sits in the output register until taken; the next sample is
//   accepted meanwhile and its result waits behind it. reset clears the
//   range to 0, loads the default gains and thresholds, drops m_tvalid.
module autorange_ohmmeter #(
    parameter int GAIN_FRAC_BITS = aom_pkg::DEF_GAIN_FRAC_BITS
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [aom_pkg::SAMPLE_W-1:0]      s_tdata,   // [15:0] sample
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [1:0] range, [33:2] resistance_ohms, [34] overflow, [39:35] zero
    output logic [aom_pkg::M_TDATA_W-1:0]          m_tdata,
    output logic                                   m_tuser,   // [0] done_res
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [aom_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [aom_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int DEN_W = aom_pkg::DIFF_W + GAIN_FRAC_BITS;     // sample << frac
    localparam int D_W   = DEN_W + 1;                            // divisor 2*den
    localparam int N_W   = aom_pkg::PROD_W + 2;                  // 2*num + den
    localparam int CNT_W = $clog2(aom_pkg::OHMS_W);

    aom_pkg::seq_state_t state_reg, state_next;

    logic [aom_pkg::GAIN_W-1:0]   gain_reg [4];
    logic [aom_pkg::THRESH_W-1:0] low_reg, high_reg;
    logic [aom_pkg::RANGE_W-1:0]  range_reg;

    logic [aom_pkg::DIFF_W-1:0]   sample_reg;     // positive sample, 1..32767
    logic [aom_pkg::PROD_W-1:0]   prod_reg;
    logic [D_W-1:0]               rem_reg;
    logic [aom_pkg::OHMS_W-1:0]   nlo_reg;
    logic [CNT_W-1:0]             cnt_reg;

    logic [aom_pkg::RANGE_W-1:0]  res_range_reg;
    logic                         res_done_reg;
    logic                         res_ovf_reg;
    logic [aom_pkg::OHMS_W-1:0]   res_ohms_reg;   // also the quotient shifter

    logic                         m_valid_reg;
    logic [aom_pkg::RANGE_W-1:0]  m_range_reg;
    logic                         m_done_reg;
    logic                         m_ovf_reg;
    logic [aom_pkg::OHMS_W-1:0]   m_ohms_reg;

    // input decision
    logic                         s_acc;
    logic signed [aom_pkg::SAMPLE_W-1:0] s_val;
    logic                         le_lo, ge_hi, rng_ok, pos;
    logic [aom_pkg::RANGE_W-1:0]  rg_step;

    // shared multiplier
    logic [aom_pkg::MUL_A_W-1:0]  mul_a;
    logic [aom_pkg::SERIES_W-1:0] mul_b;
    logic [aom_pkg::PROD_W-1:0]   mul_p;
    logic [aom_pkg::DIFF_W-1:0]   diff;

    // divider
    logic [D_W-1:0]               div_d;
    logic [N_W-1:0]               n_sum;
    logic [D_W:0]                 trial;
    logic                         qbit;
    logic                         out_load;

    assign s_acc  = s_tvalid && s_tready;
    assign s_val  = $signed(s_tdata);
    assign le_lo  = s_val <= $signed({1'b0, low_reg});
    assign ge_hi  = s_val >= $signed({1'b0, high_reg});
    assign rng_ok = (!le_lo && !ge_hi) || (le_lo && range_reg == aom_pkg::RANGE_MAX) ||
                    (ge_hi && range_reg == aom_pkg::RANGE_MIN);
    assign pos    = s_val > $signed(16'sd0);
    assign rg_step = le_lo ? range_reg + 2'd1 : range_reg - 2'd1;

    assign diff  = aom_pkg::DIFF_W'(17'd32768 - {2'b00, sample_reg});
    assign mul_a = state_reg == aom_pkg::ST_MUL1
                 ? {aom_pkg::GAIN_W'(0), diff}
                 : prod_reg[aom_pkg::MUL_A_W-1:0];
    assign mul_b = state_reg == aom_pkg::ST_MUL1
                 ? {4'b0000, gain_reg[res_range_reg]}
                 : aom_pkg::series_ohms(res_range_reg);
    assign mul_p = aom_pkg::PROD_W'(mul_a) * aom_pkg::PROD_W'(mul_b);

    assign div_d = {sample_reg, (GAIN_FRAC_BITS + 1)'(0)};
    assign n_sum = {1'b0, prod_reg, 1'b0} + N_W'({sample_reg, GAIN_FRAC_BITS'(0)});
    assign trial = {rem_reg, nlo_reg[aom_pkg::OHMS_W-1]} - {1'b0, div_d};
    assign qbit  = !trial[D_W];

    assign out_load = state_reg == aom_pkg::ST_FIN && (!m_valid_reg || m_tready);
    assign s_tready = state_reg == aom_pkg::ST_IDLE;
    assign cfg_ready = 1'b1;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            aom_pkg::ST_IDLE: begin
                if (s_acc) begin
                    state_next = (rng_ok && pos) ? aom_pkg::ST_MUL1 : aom_pkg::ST_FIN;
                end
            end
            aom_pkg::ST_MUL1: state_next = aom_pkg::ST_MUL2;
            aom_pkg::ST_MUL2: state_next = aom_pkg::ST_SUM;
            aom_pkg::ST_SUM:  state_next = aom_pkg::ST_CHK;
            aom_pkg::ST_CHK: begin
                state_next = (rem_reg >= div_d) ? aom_pkg::ST_FIN : aom_pkg::ST_DIV;
            end
            aom_pkg::ST_DIV: begin
                if (cnt_reg == CNT_W'(aom_pkg::OHMS_W - 1)) begin
                    state_next = aom_pkg::ST_FIN;
                end
            end
            aom_pkg::ST_FIN: begin
                if (out_load) begin
                    state_next = aom_pkg::ST_IDLE;
                end
            end
            default: state_next = aom_pkg::ST_IDLE;
        endcase
    end

    // control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= aom_pkg::ST_IDLE;
            range_reg   <= aom_pkg::RANGE_MIN;
            gain_reg[0] <= aom_pkg::GAIN0_RST;
            gain_reg[1] <= aom_pkg::GAIN1_RST;
            gain_reg[2] <= aom_pkg::GAIN2_RST;
            gain_reg[3] <= aom_pkg::GAIN3_RST;
            low_reg     <= aom_pkg::LOW_RST;
            high_reg    <= aom_pkg::HIGH_RST;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_acc && !rng_ok) begin
                range_reg <= rg_step;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    aom_pkg::REG_GAIN0: gain_reg[0] <= cfg_data;
                    aom_pkg::REG_GAIN1: gain_reg[1] <= cfg_data;
                    aom_pkg::REG_GAIN2: gain_reg[2] <= cfg_data;
                    aom_pkg::REG_GAIN3: gain_reg[3] <= cfg_data;
                    aom_pkg::REG_LOW:   low_reg  <= cfg_data[aom_pkg::THRESH_W-1:0];
                    aom_pkg::REG_HIGH:  high_reg <= cfg_data[aom_pkg::THRESH_W-1:0];
                    default: ;
                endcase
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            aom_pkg::ST_IDLE: begin
                if (s_acc) begin
                    sample_reg <= s_tdata[aom_pkg::DIFF_W-1:0];
                    res_range_reg <= rng_ok ? range_reg : rg_step;
                    res_done_reg  <= rng_ok;
                    res_ovf_reg   <= rng_ok;
                    res_ohms_reg  <= rng_ok ? '1 : '0;
                end
            end
            aom_pkg::ST_MUL1, aom_pkg::ST_MUL2: begin
                prod_reg <= mul_p;
            end
            aom_pkg::ST_SUM: begin
                rem_reg <= D_W'(n_sum[N_W-1:aom_pkg::OHMS_W]);
                nlo_reg <= n_sum[aom_pkg::OHMS_W-1:0];
            end
            aom_pkg::ST_CHK: begin
                cnt_reg <= '0;
            end
            aom_pkg::ST_DIV: begin
                if (qbit) begin
                    rem_reg <= trial[D_W-1:0];
                end else begin
                    rem_reg <= {rem_reg[D_W-2:0], nlo_reg[aom_pkg::OHMS_W-1]};
                end
                nlo_reg      <= {nlo_reg[aom_pkg::OHMS_W-2:0], 1'b0};
                res_ohms_reg <= {res_ohms_reg[aom_pkg::OHMS_W-2:0], qbit};
                cnt_reg      <= cnt_reg + CNT_W'(1);
                // quotient fits, clear the saturation flag
                res_ovf_reg  <= 1'b0;
            end
            default: ;
        endcase
        if (out_load) begin
            m_range_reg <= res_range_reg;
            m_done_reg  <= res_done_reg;
            m_ovf_reg   <= res_ovf_reg;
            m_ohms_reg  <= res_ohms_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_done_reg;
    assign m_tdata  = {5'b00000, m_ovf_reg, m_ohms_reg, m_range_reg};

endmodule

`default_nettype wire

// ===== hw/rtl/aom_checker.sv =====
// aom_checker: port-level checks on autorange_ohmmeter and its bind
// depends on aom_pkg; attached to the top level below
`default_nettype none

module aom_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [aom_pkg::M_TDATA_W-1:0]    m_tdata,
    input wire logic                             m_tuser
);

    // one sample at a time: no beat right after an accepted one
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("s_tready high right after an input beat");

    // a range change carries no resistance and no overflow
    a_step_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[33:2] == 32'd0 && !m_tdata[34])
        else $error("range change beat with resistance or overflow set");

    // overflow always comes with a saturated resistance
    a_ovf_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[34] |-> m_tuser && m_tdata[33:2] == 32'hFFFF_FFFF)
        else $error("overflow without saturated resistance");

    // padding bits stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[39:35] == 5'd0)
        else $error("nonzero padding in m_tdata");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output beat changed while stalled");

endmodule

bind autorange_ohmmeter aom_checker u_aom_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== sim/autorange_ohmmeter_tb.sv =====
// autorange_ohmmeter_tb: self-checking bench for the autoranging ohmmeter
// predicts every reading as its sample beat is taken; depends on aom_pkg and the dut
module autorange_ohmmeter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int ITEMS_PER_PHASE = 105;
    localparam int LAST_PHASE      = 5;
    localparam logic [aom_pkg::CFG_INDEX_W-1:0] REG_SPARE6 = 3'd6;
    localparam logic [aom_pkg::CFG_INDEX_W-1:0] REG_SPARE7 = 3'd7;
    localparam logic [aom_pkg::OHMS_W-1:0]      OHMS_SAT   = '1;

    typedef struct packed {
        logic [aom_pkg::RANGE_W-1:0] rng;
        logic                        done;
        logic [aom_pkg::OHMS_W-1:0]  ohms;
        logic                        ovf;
    } reading_t;

    typedef struct packed {
        logic [aom_pkg::SAMPLE_W-1:0] adc;
        logic                         typed;
        reading_t                     want;
    } dir_row_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [aom_pkg::SAMPLE_W-1:0]    s_tdata   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [aom_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                            m_tuser;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [aom_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [aom_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    // shadow of the meter: gains, thresholds and the range it sits in
    logic [aom_pkg::GAIN_W-1:0]   meter_gain [4];
    logic [aom_pkg::THRESH_W-1:0] meter_low;
    logic [aom_pkg::THRESH_W-1:0] meter_high;
    logic [aom_pkg::RANGE_W-1:0]  meter_range;

    reading_t pending_readings [$];
    dir_row_t dir_rows [$];
    int  mismatches    = 0;
    int  samples_sent  = 0;
    int  readings_seen = 0;
    int  range_steps   = 0;
    int  saturated     = 0;
    int  quiet_cycles  = 0;
    bit  idle_on       = 1'b1;

    autorange_ohmmeter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic reading_t make_reading(input logic [aom_pkg::RANGE_W-1:0] rng,
                                              input logic done,
                                              input logic [aom_pkg::OHMS_W-1:0] ohms,
                                              input logic ovf);
        reading_t r;
        r.rng  = rng;
        r.done = done;
        r.ohms = ohms;
        r.ovf  = ovf;
        return r;
    endfunction

    function automatic void add_row(input logic [aom_pkg::SAMPLE_W-1:0] adc,
                                    input logic typed, input reading_t want);
        dir_row_t row;
        row.adc   = adc;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endfunction

    // range decision, then R*(32768-s)*gain / (s*2^frac) rounded half up
    function automatic reading_t predict_reading(
        input logic signed [aom_pkg::SAMPLE_W-1:0] adc);
        reading_t    r;
        int          s;
        int          lo;
        int          hi;
        logic [63:0] series;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        bit          accepted;
        s  = int'(adc);
        lo = int'(meter_low);
        hi = int'(meter_high);
        r  = '0;
        accepted = (s > lo && s < hi) || (s <= lo && meter_range == aom_pkg::RANGE_MAX) ||
                   (s >= hi && meter_range == aom_pkg::RANGE_MIN);
        if (!accepted) begin
            meter_range = (s <= lo) ? meter_range + 2'd1 : meter_range - 2'd1;
            r.rng = meter_range;
            return r;
        end
        r.rng  = meter_range;
        r.done = 1'b1;
        if (s <= 0) begin
            r.ohms = OHMS_SAT;
            r.ovf  = 1'b1;
            return r;
        end
        case (meter_range)
            aom_pkg::RANGE_MIN: series = 64'd1000;
            2'd1:               series = 64'd10000;
            2'd2:               series = 64'd100000;
            default:            series = 64'd1000000;
        endcase
        num = series * 64'(32768 - s) * 64'(meter_gain[meter_range]);
        den = 64'(s) << aom_pkg::DEF_GAIN_FRAC_BITS;
        q   = (64'd2 * num + den) / (64'd2 * den);
        if (q > 64'(OHMS_SAT)) begin
            r.ohms = OHMS_SAT;
            r.ovf  = 1'b1;
        end else begin
            r.ohms = q[aom_pkg::OHMS_W-1:0];
        end
        return r;
    endfunction

    // mostly in-window and near-threshold counts so every range gets reached
    function automatic logic [aom_pkg::SAMPLE_W-1:0] pick_sample();
        int lo;
        int hi;
        int v;
        lo = int'(meter_low);
        hi = int'(meter_high);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = (hi - lo >= 2) ? $urandom_range(lo + 1, hi - 1) : $urandom;
            4:          v = lo + $urandom_range(0, 4) - 2;
            5:          v = hi + $urandom_range(0, 4) - 2;
            6:          v = $urandom_range(1, (lo > 1) ? lo : 1);
            7:          v = $urandom_range(hi, 32767);
            8:          v = -$urandom_range(0, 32768);
            default:    v = $urandom;
        endcase
        return v[aom_pkg::SAMPLE_W-1:0];
    endfunction

    task automatic send_sample(input logic [aom_pkg::SAMPLE_W-1:0] adc, input logic typed,
                               input reading_t want);
        reading_t predicted;
        int       gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= adc;
        do @(posedge aclk); while (!s_tready);
        predicted = predict_reading(adc);
        pending_readings.push_back(typed ? want : predicted);
        samples_sent++;
    endtask

    task automatic write_reg(input logic [aom_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [aom_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            aom_pkg::REG_GAIN0, aom_pkg::REG_GAIN1,
            aom_pkg::REG_GAIN2, aom_pkg::REG_GAIN3: meter_gain[idx[1:0]] = value;
            aom_pkg::REG_LOW:  meter_low  = value[aom_pkg::THRESH_W-1:0];
            aom_pkg::REG_HIGH: meter_high = value[aom_pkg::THRESH_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [aom_pkg::GAIN_W-1:0] g0,
                                 input logic [aom_pkg::GAIN_W-1:0] g1,
                                 input logic [aom_pkg::GAIN_W-1:0] g2,
                                 input logic [aom_pkg::GAIN_W-1:0] g3,
                                 input logic [aom_pkg::CFG_DATA_W-1:0] lo,
                                 input logic [aom_pkg::CFG_DATA_W-1:0] hi);
        write_reg(aom_pkg::REG_GAIN0, g0);
        write_reg(aom_pkg::REG_GAIN1, g1);
        write_reg(aom_pkg::REG_GAIN2, g2);
        write_reg(aom_pkg::REG_GAIN3, g3);
        write_reg(aom_pkg::REG_LOW, lo);
        write_reg(aom_pkg::REG_HIGH, hi);
        // indexes past the register map must leave everything alone
        write_reg(REG_SPARE6, aom_pkg::CFG_DATA_W'($urandom));
        write_reg(REG_SPARE7, aom_pkg::CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [aom_pkg::GAIN_W-1:0] rand_gain(input int unsigned lo,
                                                             input int unsigned hi);
        return aom_pkg::GAIN_W'($urandom_range(lo, hi));
    endfunction

    task automatic wait_drained();
        while (pending_readings.size() != 0) @(posedge aclk);
    endtask

    initial begin
        int lo_pick;
        meter_gain[0] = aom_pkg::GAIN0_RST;
        meter_gain[1] = aom_pkg::GAIN1_RST;
        meter_gain[2] = aom_pkg::GAIN2_RST;
        meter_gain[3] = aom_pkg::GAIN3_RST;
        meter_low     = aom_pkg::LOW_RST;
        meter_high    = aom_pkg::HIGH_RST;
        meter_range   = aom_pkg::RANGE_MIN;

        // starts in range 0 with reset thresholds 8000 / 24000
        add_row(16'd16000, 1'b0, '0);
        add_row(16'h7FFF,  1'b1, make_reading(aom_pkg::RANGE_MIN, 1'b1, '0, 1'b0));
        add_row(16'd24000, 1'b0, '0);
        add_row(16'd8000,  1'b1, make_reading(2'd1, 1'b0, '0, 1'b0));
        add_row(16'h8000,  1'b1, make_reading(2'd2, 1'b0, '0, 1'b0));
        add_row(16'h0000,  1'b1, make_reading(aom_pkg::RANGE_MAX, 1'b0, '0, 1'b0));
        // at the top range a nonpositive count saturates
        add_row(16'h0000,  1'b1, make_reading(aom_pkg::RANGE_MAX, 1'b1, OHMS_SAT, 1'b1));
        add_row(16'h8000,  1'b1, make_reading(aom_pkg::RANGE_MAX, 1'b1, OHMS_SAT, 1'b1));
        add_row(16'hFFFF,  1'b1, make_reading(aom_pkg::RANGE_MAX, 1'b1, OHMS_SAT, 1'b1));
        // one count against 1M ohm does not fit in 32 bits
        add_row(16'h0001,  1'b1, make_reading(aom_pkg::RANGE_MAX, 1'b1, OHMS_SAT, 1'b1));
        add_row(16'd8000,  1'b0, '0);
        add_row(16'd8001,  1'b0, '0);
        add_row(16'd23999, 1'b0, '0);
        add_row(16'd24000, 1'b1, make_reading(2'd2, 1'b0, '0, 1'b0));
        add_row(16'h7FFF,  1'b1, make_reading(2'd1, 1'b0, '0, 1'b0));
        add_row(16'd23999, 1'b0, '0);
        add_row(16'd24000, 1'b1, make_reading(aom_pkg::RANGE_MIN, 1'b0, '0, 1'b0));
        add_row(16'd16384, 1'b0, '0);
        add_row(16'd8001,  1'b0, '0);
        add_row(16'hAAAA,  1'b1, make_reading(2'd1, 1'b0, '0, 1'b0));
        add_row(16'h5555,  1'b0, '0);
        add_row(16'd24000, 1'b1, make_reading(aom_pkg::RANGE_MIN, 1'b0, '0, 1'b0));
        add_row(16'd24000, 1'b0, '0);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i])
            send_sample(dir_rows[i].adc, dir_rows[i].typed, dir_rows[i].want);
        s_tvalid <= 1'b0;

        for (int ph = 1; ph <= LAST_PHASE; ph++) begin
            wait_drained();
            case (ph)
                1: load_settings('1, '1, '1, '1, 16'h0000, 16'h7FFF);
                // inverted window, bit 15 of each threshold word is dropped
                2: load_settings('0, '0, '0, '0, 16'hFFFF, 16'h8000);
                3: begin
                    lo_pick = int'($urandom_range(0, 16000));
                    load_settings(rand_gain(0, 65535), rand_gain(0, 65535),
                                  rand_gain(0, 65535), rand_gain(0, 65535),
                                  aom_pkg::CFG_DATA_W'(lo_pick),
                                  aom_pkg::CFG_DATA_W'(lo_pick + $urandom_range(1, 16000)));
                end
                4: load_settings(rand_gain(0, 65535), rand_gain(0, 65535),
                                 rand_gain(0, 65535), rand_gain(0, 65535),
                                 aom_pkg::CFG_DATA_W'($urandom),
                                 aom_pkg::CFG_DATA_W'($urandom));
                default: load_settings(rand_gain(12000, 20000), rand_gain(12000, 20000),
                                       rand_gain(12000, 20000), rand_gain(12000, 20000),
                                       16'd8000, 16'd24000);
            endcase
            idle_on = (ph != LAST_PHASE);
            repeat (ITEMS_PER_PHASE) send_sample(pick_sample(), 1'b0, '0);
            s_tvalid <= 1'b0;
        end

        wait_drained();
        repeat (60) @(posedge aclk);
        if (pending_readings.size() != 0) begin
            $error("%0d readings never arrived", pending_readings.size());
            mismatches++;
        end
        $display("%0d samples, %0d readings checked across %0d register settings",
                 samples_sent, readings_seen, LAST_PHASE + 1);
        $display("%0d range steps, %0d saturated readings, %0d mismatches",
                 range_steps, saturated, mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // result sink with bursts of back-pressure
    initial begin
        forever begin
            @(posedge aclk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        reading_t got;
        reading_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.rng  = m_tdata[aom_pkg::RANGE_W-1:0];
            got.ohms = m_tdata[aom_pkg::RANGE_W +: aom_pkg::OHMS_W];
            got.ovf  = m_tdata[aom_pkg::RANGE_W + aom_pkg::OHMS_W];
            got.done = m_tuser;
            if (pending_readings.size() == 0) begin
                $error("reading beat with none expected: tdata %h tuser %b", m_tdata, m_tuser);
                mismatches++;
            end else begin
                want = pending_readings.pop_front();
                readings_seen++;
                if (!want.done)
                    range_steps++;
                else if (want.ovf)
                    saturated++;
                if (got.rng !== want.rng) begin
                    $error("range: expected %0d, actual %0d", want.rng, got.rng);
                    mismatches++;
                end
                if (got.done !== want.done) begin
                    $error("done_res: expected %0d, actual %0d", want.done, got.done);
                    mismatches++;
                end
                if (got.ohms !== want.ohms) begin
                    $error("resistance_ohms: expected %0d, actual %0d", want.ohms, got.ohms);
                    mismatches++;
                end
                if (got.ovf !== want.ovf) begin
                    $error("overflow: expected %0d, actual %0d", want.ovf, got.ovf);
                    mismatches++;
                end
                if (m_tdata[aom_pkg::M_TDATA_W-1:aom_pkg::RANGE_W+aom_pkg::OHMS_W+1] !== '0)
                begin
                    $error("tdata pad: expected 0, actual %h",
                           m_tdata[aom_pkg::M_TDATA_W-1:aom_pkg::RANGE_W+aom_pkg::OHMS_W+1]);
                    mismatches++;
                end
            end
        end
    end

    // ends a hung run: counts cycles with no beat on any channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule
